// ===== hdl/pse_pkg.sv =====
// Package: widths, payload types, register codes and the Q16 multiply for the specular evaluator
package pse_pkg;

    localparam int VEC_W     = 16;
    localparam int VEC_FRAC  = 14;
    localparam int PROD_W    = 2 * VEC_W;
    localparam int NDOT_W    = PROD_W + 1;
    localparam int N14_W     = NDOT_W - VEC_FRAC;
    localparam int NP_W      = N14_W + VEC_W;
    localparam int R_W       = NP_W + 1;
    localparam int RW_W      = R_W + VEC_W;
    localparam int D_W       = RW_W + 2;
    localparam int COS_SHIFT = 26;
    localparam int Q16_W     = 17;
    localparam int COL_W     = 16;
    localparam int CC_W      = 2 * COL_W;
    localparam int CP_W      = CC_W + Q16_W;
    localparam int CH_SHIFT  = 32;
    localparam int SHIN_W    = 10;
    localparam int EXP_BITS  = 10;
    localparam int EXP_EXT   = (EXP_BITS > SHIN_W) ? EXP_BITS : SHIN_W;
    localparam int ROUND_Q14 = 2 ** (VEC_FRAC - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [Q16_W-1:0] ONE_Q16 = Q16_W'(1) << 16;

    localparam logic [COL_W-1:0]  RST_COLOR = '1;
    localparam logic [COL_W-1:0]  RST_COEF  = COL_W'(4096);
    localparam logic [SHIN_W-1:0] RST_SHIN  = SHIN_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_RED,
        CFG_COLOR_GREEN,
        CFG_COLOR_BLUE,
        CFG_SPEC_COEF,
        CFG_SHININESS
    } t_cfg_reg;

    typedef struct packed {
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
        logic signed [VEC_W-1:0] incoming_x;
        logic signed [VEC_W-1:0] incoming_y;
        logic signed [VEC_W-1:0] incoming_z;
        logic signed [VEC_W-1:0] outgoing_x;
        logic signed [VEC_W-1:0] outgoing_y;
        logic signed [VEC_W-1:0] outgoing_z;
    } t_query;

    typedef struct packed {
        logic [COL_W-1:0] result_red;
        logic [COL_W-1:0] result_green;
        logic [COL_W-1:0] result_blue;
        logic             lobe_hit;
    } t_result;

    // rounded UQ1.16 product; both operands stay at or below one
    function automatic logic [Q16_W-1:0] mul_q16(input logic [Q16_W-1:0] a,
                                                 input logic [Q16_W-1:0] b);
        logic [2*Q16_W-1:0] p;
        p = ((2*Q16_W)'(a) * (2*Q16_W)'(b)) + (2*Q16_W)'(32768);
        return p[Q16_W+15:16];
    endfunction

endpackage

// ===== hdl/pse_query_if.sv =====
// Interface: query channel carrying normal, incoming and outgoing vectors
interface pse_query_if;
    logic            valid;
    logic            ready;
    pse_pkg::t_query data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pse_result_if.sv =====
// Interface: result channel carrying the three radiance channels and the lobe flag
interface pse_result_if;
    logic             valid;
    logic             ready;
    pse_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pse_cfg_if.sv =====
// Interface: configuration write channel with register index and write data
interface pse_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pse_pkg::CFG_IDX_W-1:0]    index;
    logic [pse_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/phong_specular_eval.sv =====
// Top level: pipelined Phong specular evaluator, reflection, lobe cosine, power and colour
//
// Takes one shading query per cycle unless the output stalls, and returns one result per
// query, in order, through 7 vector stages, one square-and-multiply stage per exponent
// bit, that is EXP_BITS = 10, then two colour stages. The whole pipeline moves as one:
// it holds while a finished result waits at the output and is not taken, so query ready
// follows result ready combinationally through that single output register.
// The configuration port is always ready; write it only while no query is in flight.
module phong_specular_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pse_query_if.sink    i_query,
    pse_cfg_if.sink      i_cfg,
    pse_result_if.source o_result
);
    import pse_pkg::*;

    localparam logic [CP_W-1:0] CH_HALF = CP_W'(1) << (CH_SHIFT - 1);

    logic [COL_W-1:0]  r_color [3];
    logic [COL_W-1:0]  r_coef;
    logic [SHIN_W-1:0] r_shininess;
    logic [CC_W-1:0]   r_cc [3];

    logic w_adv;

    logic                      r_s1_valid;
    logic signed [PROD_W-1:0]  r_s1_prod [3];
    logic signed [VEC_W-1:0]   r_s1_n [3];
    logic signed [VEC_W-1:0]   r_s1_v [3];
    logic signed [VEC_W-1:0]   r_s1_w [3];

    logic                      r_s2_valid;
    logic signed [N14_W-1:0]   r_s2_ndot14;
    logic signed [VEC_W-1:0]   r_s2_n [3];
    logic signed [VEC_W-1:0]   r_s2_v [3];
    logic signed [VEC_W-1:0]   r_s2_w [3];

    logic                      r_s3_valid;
    logic signed [NP_W-1:0]    r_s3_np [3];
    logic signed [VEC_W-1:0]   r_s3_v [3];
    logic signed [VEC_W-1:0]   r_s3_w [3];

    logic                      r_s4_valid;
    logic signed [R_W-1:0]     r_s4_r [3];
    logic signed [VEC_W-1:0]   r_s4_w [3];

    logic                      r_s5_valid;
    logic signed [RW_W-1:0]    r_s5_rw [3];

    logic                      r_s6_valid;
    logic signed [D_W-1:0]     r_s6_d;

    logic                      r_s7_valid;
    logic                      r_s7_hit;
    logic [Q16_W-1:0]          r_s7_c;

    logic                      r_pw_valid [EXP_BITS];
    logic                      r_pw_hit   [EXP_BITS];
    logic [Q16_W-1:0]          r_acc      [EXP_BITS];
    logic [Q16_W-1:0]          r_base     [EXP_BITS];
    logic                      w_pw_valid_in [EXP_BITS];
    logic                      w_pw_hit_in   [EXP_BITS];
    logic [Q16_W-1:0]          w_acc_in      [EXP_BITS];
    logic [Q16_W-1:0]          w_base_in     [EXP_BITS];
    logic [EXP_EXT-1:0]        w_exp;

    logic                      r_s8_valid;
    logic                      r_s8_hit;
    logic [CP_W-1:0]           r_s8_prod [3];

    logic                      r_out_valid;
    t_result                   r_out;

    logic signed [VEC_W-1:0]   w_qn [3];
    logic signed [VEC_W-1:0]   w_qv [3];
    logic signed [VEC_W-1:0]   w_qw [3];
    logic signed [NDOT_W-1:0]  w_ndot;
    logic signed [NDOT_W-1:0]  w_ndot_sh;
    logic [D_W-COS_SHIFT-1:0]  w_cos_q;
    logic [CP_W-1:0]           w_rnd [3];
    logic [COL_W-1:0]          w_sat [3];

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color[0]  <= RST_COLOR;
            r_color[1]  <= RST_COLOR;
            r_color[2]  <= RST_COLOR;
            r_coef      <= RST_COEF;
            r_shininess <= RST_SHIN;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_COLOR_RED:   r_color[0]  <= i_cfg.data[COL_W-1:0];
                CFG_COLOR_GREEN: r_color[1]  <= i_cfg.data[COL_W-1:0];
                CFG_COLOR_BLUE:  r_color[2]  <= i_cfg.data[COL_W-1:0];
                CFG_SPEC_COEF:   r_coef      <= i_cfg.data[COL_W-1:0];
                CFG_SHININESS:   r_shininess <= i_cfg.data[SHIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_cc[k] <= CC_W'(r_color[k]) * CC_W'(r_coef);
        end
    end

    assign w_adv         = !r_out_valid || o_result.ready;
    assign i_query.ready = w_adv;

    assign w_qn[0] = i_query.data.normal_x;
    assign w_qn[1] = i_query.data.normal_y;
    assign w_qn[2] = i_query.data.normal_z;
    assign w_qv[0] = i_query.data.incoming_x;
    assign w_qv[1] = i_query.data.incoming_y;
    assign w_qv[2] = i_query.data.incoming_z;
    assign w_qw[0] = i_query.data.outgoing_x;
    assign w_qw[1] = i_query.data.outgoing_y;
    assign w_qw[2] = i_query.data.outgoing_z;

    assign w_ndot    = NDOT_W'(r_s1_prod[0]) + NDOT_W'(r_s1_prod[1]) + NDOT_W'(r_s1_prod[2])
                       + NDOT_W'(ROUND_Q14);
    assign w_ndot_sh = w_ndot >>> VEC_FRAC;
    assign w_cos_q   = r_s6_d[D_W-1:COS_SHIFT];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < EXP_BITS; s++) begin
                r_pw_valid[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_s1_valid  <= i_query.valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= r_pw_valid[EXP_BITS-1];
            r_out_valid <= r_s8_valid;
            for (int s = 0; s < EXP_BITS; s++) begin
                r_pw_valid[s] <= w_pw_valid_in[s];
            end
        end
    end

    // reflection and lobe cosine
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_prod[k] <= PROD_W'(w_qn[k]) * PROD_W'(w_qv[k]);
                r_s1_n[k]    <= w_qn[k];
                r_s1_v[k]    <= w_qv[k];
                r_s1_w[k]    <= w_qw[k];

                r_s2_n[k]    <= r_s1_n[k];
                r_s2_v[k]    <= r_s1_v[k];
                r_s2_w[k]    <= r_s1_w[k];

                r_s3_np[k]   <= NP_W'(r_s2_ndot14) * NP_W'(r_s2_n[k]);
                r_s3_v[k]    <= r_s2_v[k];
                r_s3_w[k]    <= r_s2_w[k];

                r_s4_r[k]    <= (R_W'(r_s3_np[k]) <<< 1) - (R_W'(r_s3_v[k]) <<< VEC_FRAC);
                r_s4_w[k]    <= r_s3_w[k];

                r_s5_rw[k]   <= RW_W'(r_s4_r[k]) * RW_W'(r_s4_w[k]);
            end
            r_s2_ndot14 <= N14_W'(w_ndot_sh);
            r_s6_d      <= D_W'(r_s5_rw[0]) + D_W'(r_s5_rw[1]) + D_W'(r_s5_rw[2]);
            r_s7_hit    <= (r_s6_d > 0);
            if (r_s6_d <= 0) begin
                r_s7_c <= '0;
            end else if (w_cos_q > (D_W-COS_SHIFT)'(ONE_Q16)) begin
                r_s7_c <= ONE_Q16;
            end else begin
                r_s7_c <= w_cos_q[Q16_W-1:0];
            end
        end
    end

    // square-and-multiply, one exponent bit per stage, low bit first
    assign w_exp = EXP_EXT'(r_shininess);

    for (genvar g = 0; g < EXP_BITS; g++) begin : g_pw
        if (g == 0) begin : g_first
            assign w_pw_valid_in[g] = r_s7_valid;
            assign w_pw_hit_in[g]   = r_s7_hit;
            assign w_acc_in[g]      = ONE_Q16;
            assign w_base_in[g]     = r_s7_c;
        end else begin : g_next
            assign w_pw_valid_in[g] = r_pw_valid[g-1];
            assign w_pw_hit_in[g]   = r_pw_hit[g-1];
            assign w_acc_in[g]      = r_acc[g-1];
            assign w_base_in[g]     = r_base[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pw_hit[g] <= w_pw_hit_in[g];
                r_acc[g]    <= w_exp[g] ? mul_q16(w_acc_in[g], w_base_in[g]) : w_acc_in[g];
                r_base[g]   <= mul_q16(w_base_in[g], w_base_in[g]);
            end
        end
    end

    // colour scaling, rounding and saturation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rnd[k] = r_s8_prod[k] + CH_HALF;
            w_sat[k] = (w_rnd[k][CP_W-1:CH_SHIFT+COL_W] != '0) ? '1
                                                               : w_rnd[k][CH_SHIFT+COL_W-1:CH_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_s8_prod[k] <= CP_W'(r_cc[k]) * CP_W'(r_acc[EXP_BITS-1]);
            end
            r_s8_hit <= r_pw_hit[EXP_BITS-1];

            r_out.result_red   <= r_s8_hit ? w_sat[0] : '0;
            r_out.result_green <= r_s8_hit ? w_sat[1] : '0;
            r_out.result_blue  <= r_s8_hit ? w_sat[2] : '0;
            r_out.lobe_hit     <= r_s8_hit;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    a_miss_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.data.lobe_hit) |->
        (o_result.data.result_red == '0 && o_result.data.result_green == '0
         && o_result.data.result_blue == '0))
        else $error("lobe miss with non-black result");

    a_cos_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s7_valid |-> (r_s7_c <= ONE_Q16 && (r_s7_hit || r_s7_c == '0)))
        else $error("lobe cosine out of range");

    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pw_valid[EXP_BITS-1] |-> (r_acc[EXP_BITS-1] <= ONE_Q16))
        else $error("power above one");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && !r_s8_valid) |=> !o_result.valid)
        else $error("result repeated after transfer");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_s8_valid) && $stable(r_s7_valid) && $stable(r_s1_valid)))
        else $error("pipeline moved during stall");

endmodule
